// ----- hdl/hep_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hep_pkg
// Shared constants, request codes and types of the Huffman encoder bit packer.
// ----------------------------------------------------------------------------
package hep_pkg;

   // table geometry
   localparam int MAX_CODE_LEN = 32;
   localparam int NUM_SYMBOLS  = 257;

   // fixed field widths
   localparam int REQ_W    = 2;
   localparam int SYM_W    = 9;
   localparam int BITS_W   = 32;
   localparam int CLEN_W   = 6;
   localparam int BYTE_W   = 8;

   // pending bit store: at most seven bits between bytes
   localparam int ACC_W    = 7;
   localparam int CNT_W    = 3;

   // derived widths
   localparam int ADDR_W    = $clog2(NUM_SYMBOLS);
   localparam int CODE_W    = MAX_CODE_LEN;
   localparam int LENS_W    = $clog2(MAX_CODE_LEN + 1);
   localparam int ENTRY_W   = CODE_W + LENS_W;
   localparam int MAX_BYTES = (ACC_W + MAX_CODE_LEN + 7) / 8;
   localparam int BUF_W     = MAX_BYTES * BYTE_W;
   localparam int REM_W     = $clog2(MAX_BYTES + 1);
   localparam int NBIT_W    = $clog2(BUF_W + 1);
   localparam int SYMCMP_W  = SYM_W + 1;

   // table index of the end-of-data code
   localparam logic [ADDR_W-1:0] END_ADDR = ADDR_W'(NUM_SYMBOLS - 1);

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FINISH = 2'd2
   } req_code_type;

   // looked-up code handed from the table to the packer
   typedef struct packed {
      logic              vld;
      logic              fin;
      logic [LENS_W-1:0] len;
      logic [CODE_W-1:0] code;
   } lookup_type;

   // mask of the low len bits of a code word
   function automatic logic [CODE_W-1:0] code_mask(input logic [LENS_W-1:0] len);
      logic [CODE_W-1:0] m;
      for (int i = 0; i < CODE_W; i++) begin
         m[i] = (LENS_W'(i) < len);
      end
      return m;
   endfunction

endpackage

// ----- hdl/huffman_encoder_bit_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_encoder_bit_packer
// Huffman encoder with a loadable code table and an MSB-first byte packer.
//
// Usage: the req channel takes one word per cycle: req_type selects load
// (write code and length of entry req_symbol), encode (append the code of
// req_symbol) or finish (append the end-of-data code, zero-pad, flag the last
// byte). The rsp channel returns packed bytes, earliest bit in bit 7; rsp_last
// marks the final byte of one request, rsp_stream_end the final padded byte of
// a finish. Both channels use valid/stall, accepted when valid and not stall.
// Path: a request's code is read into the table's registered read data, then
// merged into the byte buffer register that the rsp channel sends from.
// Throughput: one request per cycle while each gives at most one byte and
// rsp_stall stays low; loads produce no bytes. A request giving more bytes
// (up to five) holds the byte buffer while rsp sends one per unstalled cycle.
// Reset: no pending bits; a clearing pass then writes all 257 table entries
// empty (length zero), one per cycle, with req_stall high until it ends.
// Stall: when rsp_stall holds, the byte buffer and the lookup stage fill and
// req_stall rises; no byte is lost or repeated.
// ----------------------------------------------------------------------------
module huffman_encoder_bit_packer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [hep_pkg::REQ_W-1:0]   req_type,
   input  logic [hep_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hep_pkg::BITS_W-1:0]  req_code_bits,
   input  logic [hep_pkg::CLEN_W-1:0]  req_code_len,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hep_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last,
   output logic                        rsp_stream_end
);

   hep_pkg::lookup_type lk;
   logic                lk_take;

   // code table and lookup stage
   hep_table u_table (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_symbol    (req_symbol),
      .req_code_bits (req_code_bits),
      .req_code_len  (req_code_len),
      .lk            (lk),
      .lk_take       (lk_take)
   );

   // bit merge and byte output
   hep_pack u_pack (
      .clock          (clock),
      .reset          (reset),
      .lk             (lk),
      .lk_take        (lk_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

// ----- hdl/hep_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hep_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module hep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/hep_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hep_table
// Code table: takes request words, writes loaded entries into the table RAM
// and reads the code for encode and finish requests. A clearing pass after
// reset writes every entry empty before the first request is taken.
// ----------------------------------------------------------------------------
module hep_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [hep_pkg::REQ_W-1:0]   req_type,
   input  logic [hep_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hep_pkg::BITS_W-1:0]  req_code_bits,
   input  logic [hep_pkg::CLEN_W-1:0]  req_code_len,
   output hep_pkg::lookup_type         lk,
   input  logic                        lk_take
);

   logic                               accept;
   logic                               is_load;
   logic                               is_enc;
   logic                               is_fin;
   logic                               sym_ok;
   logic [hep_pkg::ADDR_W-1:0]         sym_addr;
   logic [hep_pkg::ADDR_W-1:0]         rd_addr;
   logic                               rd_en;
   logic                               wr_en;
   logic                               hit;
   logic [hep_pkg::CLEN_W-1:0]         len_sat;
   logic [hep_pkg::LENS_W-1:0]         len_store;
   logic [63:0]                        bits_ext;
   logic [hep_pkg::CODE_W-1:0]         code_store;
   logic [hep_pkg::ENTRY_W-1:0]        wr_data;
   logic [hep_pkg::ENTRY_W-1:0]        rd_data;
   logic                               ram_wr_en;
   logic [hep_pkg::ADDR_W-1:0]         ram_wr_addr;
   logic [hep_pkg::ENTRY_W-1:0]        ram_wr_data;

   logic                               clr_busy_ff;
   logic                               clr_busy_in;
   logic [hep_pkg::ADDR_W-1:0]         clr_addr_ff;
   logic [hep_pkg::ADDR_W-1:0]         clr_addr_in;
   logic                               lk_vld_ff;
   logic                               lk_vld_in;
   logic                               lk_fin_ff;
   logic                               lk_hit_ff;

   // request decode
   assign accept   = req_valid & ~req_stall;
   assign is_load  = (req_type == hep_pkg::REQ_LOAD);
   assign is_enc   = (req_type == hep_pkg::REQ_ENCODE);
   assign is_fin   = (req_type == hep_pkg::REQ_FINISH);
   assign sym_ok   = ({1'b0, req_symbol} < hep_pkg::SYMCMP_W'(hep_pkg::NUM_SYMBOLS));
   assign sym_addr = sym_ok ? hep_pkg::ADDR_W'(req_symbol) : '0;
   assign rd_addr  = is_fin ? hep_pkg::END_ADDR : sym_addr;
   assign rd_en    = accept & (is_enc | is_fin);
   assign wr_en    = accept & is_load & sym_ok;
   assign hit      = is_fin | sym_ok;

   // entry to store: saturated length, code cut to that length
   always_comb begin
      len_sat = req_code_len;
      if (req_code_len > hep_pkg::CLEN_W'(hep_pkg::MAX_CODE_LEN)) begin
         len_sat = hep_pkg::CLEN_W'(hep_pkg::MAX_CODE_LEN);
      end
   end

   assign len_store  = hep_pkg::LENS_W'(len_sat);
   assign bits_ext   = 64'(req_code_bits);
   assign code_store = bits_ext[hep_pkg::CODE_W-1:0] & hep_pkg::code_mask(len_store);
   assign wr_data    = {code_store, len_store};

   // clearing pass after reset: one empty entry per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + hep_pkg::ADDR_W'(1);
         if (clr_addr_ff == hep_pkg::END_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // table write port: clearing pass or load
   assign ram_wr_en   = clr_busy_ff | wr_en;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : sym_addr;
   assign ram_wr_data = clr_busy_ff ? '0 : wr_data;

   hep_ram #(
      .WIDTH (hep_pkg::ENTRY_W),
      .DEPTH (hep_pkg::NUM_SYMBOLS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // lookup stage holds while the packer cannot take it
   assign req_stall = clr_busy_ff | (lk_vld_ff & ~lk_take);
   assign lk_vld_in = rd_en | (lk_vld_ff & ~lk_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         lk_vld_ff   <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         lk_vld_ff   <= lk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         lk_fin_ff <= is_fin;
         lk_hit_ff <= hit;
      end
   end

   // looked-up code, empty for out-of-range entries
   always_comb begin
      lk.vld  = lk_vld_ff;
      lk.fin  = lk_fin_ff;
      lk.len  = lk_hit_ff ? rd_data[hep_pkg::LENS_W-1:0] : '0;
      lk.code = lk_hit_ff ? rd_data[hep_pkg::ENTRY_W-1:hep_pkg::LENS_W] : '0;
   end

`ifndef SYNTHESIS
   a_no_lookup_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !lk_vld_ff && !wr_en)
      else $error("request taken during clearing pass");

   a_clear_pass_ends: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff && (clr_addr_ff == hep_pkg::END_ADDR) |=> !clr_busy_ff)
      else $error("clearing pass did not end at last entry");

   a_stalled_lookup_holds: assert property (@(posedge clock) disable iff (reset)
      lk_vld_ff && !lk_take |=> lk_vld_ff && $stable(rd_data) && $stable(lk_hit_ff))
      else $error("stalled lookup changed");
`endif

endmodule

// ----- hdl/hep_pack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hep_pack
// Bit packer: merges a looked-up code into the pending bits, pads on finish,
// and sends full bytes from a byte buffer, one per cycle unless rsp_stall.
// ----------------------------------------------------------------------------
module hep_pack (
   input  logic                        clock,
   input  logic                        reset,
   input  hep_pkg::lookup_type         lk,
   output logic                        lk_take,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hep_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last,
   output logic                        rsp_stream_end
);

   logic [hep_pkg::ACC_W-1:0]   acc_ff;
   logic [hep_pkg::ACC_W-1:0]   acc_in;
   logic [hep_pkg::CNT_W-1:0]   cnt_ff;
   logic [hep_pkg::CNT_W-1:0]   cnt_in;
   logic [hep_pkg::BUF_W-1:0]   buf_ff;
   logic [hep_pkg::BUF_W-1:0]   buf_in;
   logic [hep_pkg::REM_W-1:0]   rem_ff;
   logic [hep_pkg::REM_W-1:0]   rem_in;
   logic                        end_ff;
   logic                        end_in;

   logic [hep_pkg::BUF_W-1:0]   total;
   logic [hep_pkg::BUF_W-1:0]   total_pad;
   logic [hep_pkg::NBIT_W-1:0]  nbits;
   logic [hep_pkg::NBIT_W-1:0]  nbits_pad;
   logic [hep_pkg::CNT_W-1:0]   pad;
   logic [hep_pkg::REM_W-1:0]   nbytes;
   logic [hep_pkg::BYTE_W-1:0]  keep_mask;
   logic                        buf_free;
   logic                        rsp_take;
   logic                        load_buf;

   // merge code into pending bits, pad to a byte boundary on finish
   always_comb begin
      total     = (hep_pkg::BUF_W'(acc_ff) << lk.len) | hep_pkg::BUF_W'(lk.code);
      nbits     = hep_pkg::NBIT_W'(cnt_ff) + hep_pkg::NBIT_W'(lk.len);
      pad       = lk.fin ? hep_pkg::CNT_W'(4'd8 - {1'b0, nbits[2:0]}) : '0;
      total_pad = total << pad;
      nbits_pad = nbits + hep_pkg::NBIT_W'(pad);
      nbytes    = hep_pkg::REM_W'(nbits_pad >> 3);
      keep_mask = (8'd1 << nbits[2:0]) - 8'd1;
   end

   // handoff between the merge and the byte buffer
   assign rsp_valid = (rem_ff != '0);
   assign rsp_take  = rsp_valid & ~rsp_stall;
   assign buf_free  = (rem_ff == '0) || ((rem_ff == hep_pkg::REM_W'(1)) && ~rsp_stall);
   assign lk_take   = lk.vld & ((nbytes == '0) | buf_free);
   assign load_buf  = lk_take & (nbytes != '0);

   // next state of pending bits and byte buffer
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      buf_in = buf_ff;
      end_in = end_ff;
      rem_in = rem_ff;
      if (lk_take) begin
         acc_in = lk.fin ? '0 : (total[hep_pkg::ACC_W-1:0] & keep_mask[hep_pkg::ACC_W-1:0]);
         cnt_in = lk.fin ? '0 : nbits[2:0];
      end
      if (rsp_take) begin
         rem_in = rem_ff - hep_pkg::REM_W'(1);
      end
      if (load_buf) begin
         // full bytes only, the leftover bits stay pending
         buf_in = total_pad >> nbits_pad[2:0];
         end_in = lk.fin;
         rem_in = nbytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         rem_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      end_ff <= end_in;
   end

   // earliest remaining byte of the buffer
   always_comb begin
      rsp_out_byte = '0;
      for (int k = 0; k < hep_pkg::MAX_BYTES; k++) begin
         if (rem_ff == hep_pkg::REM_W'(k + 1)) begin
            rsp_out_byte = buf_ff[k*hep_pkg::BYTE_W +: hep_pkg::BYTE_W];
         end
      end
   end

   assign rsp_last       = (rem_ff == hep_pkg::REM_W'(1));
   assign rsp_stream_end = end_ff & rsp_last;

`ifndef SYNTHESIS
   a_pending_bits_clean: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, acc_ff} & ~((8'd1 << cnt_ff) - 8'd1)) == 8'd0))
      else $error("pending bits above bit count not zero");

   a_buffer_count_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= hep_pkg::REM_W'(hep_pkg::MAX_BYTES))
      else $error("byte buffer count out of range");

   a_finish_aligns: assert property (@(posedge clock) disable iff (reset)
      lk_take && lk.fin |=> cnt_ff == '0 && acc_ff == '0)
      else $error("pending bits left after finish");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load_buf |-> rem_ff == '0 || (rem_ff == hep_pkg::REM_W'(1) && rsp_take))
      else $error("byte buffer overwritten");
`endif

endmodule
